// ===== design/qte_pkg.sv =====
// Shared widths, constants, types and arithmetic helpers for the quaternion to Euler pipeline.
package qte_pkg;

    localparam int QW     = 16;  // quaternion component, Q1.14
    localparam int PW     = 32;  // component product, Q.28
    localparam int SUMW   = 35;  // doubled sums of products, Q.28
    localparam int CW     = 37;  // CORDIC x/y datapath
    localparam int AW     = 32;  // angle in Q.28 radians
    localparam int ROOTW  = 29;  // square root result
    localparam int RADW   = 57;  // square root radicand
    localparam int REMW   = 59;  // square root partial remainder
    localparam int THRW   = 11;
    localparam int AXW    = 15;
    localparam int AYW    = 16;
    localparam int RNDW   = 18;  // rounded angle before saturation

    localparam logic [THRW-1:0]      THR_RESET = 11'd16;
    localparam logic signed [SUMW-1:0] ONE_Q28 = 35'sd268435456;
    localparam logic signed [AW-1:0] PI2_Q28   = 32'sd421657428;
    localparam logic [AXW-1:0]       PIX_MAX   = 15'd12868;
    localparam logic [AXW-1:0]       PIY_MAX   = 15'd25736;

    typedef struct packed {
        logic signed [SUMW-1:0] u;      // negated, zeroed sine of the x-angle
        logic                   lock0;  // |sine| above one
        logic signed [SUMW-1:0] sy;
        logic signed [SUMW-1:0] xl;     // y-angle cosine term, lock path
        logic signed [SUMW-1:0] xn;     // y-angle cosine term, normal path
        logic signed [SUMW-1:0] zy;
        logic signed [SUMW-1:0] zx;
    } t_ops;

    // atan(2^-i) in Q.28, rounded to nearest
    function automatic logic signed [AW-1:0] atan_q28(input int i);
        logic signed [AW-1:0] a;
        case (i)
            0:       a = 32'sd210828714;
            1:       a = 32'sd124459457;
            2:       a = 32'sd65760959;
            3:       a = 32'sd33381290;
            4:       a = 32'sd16755422;
            5:       a = 32'sd8385879;
            6:       a = 32'sd4193963;
            7:       a = 32'sd2097109;
            8:       a = 32'sd1048571;
            9:       a = 32'sd524287;
            default: a = 32'sd268435456 >>> i;
        endcase
        return a;
    endfunction

    // Round Q.28 to nearest Q.13 (ties up) and clamp to +-lim
    function automatic logic signed [RNDW-1:0] q13_sat(input logic signed [AW-1:0] a,
                                                       input logic [AXW-1:0] lim);
        logic signed [AW:0]     sum;
        logic signed [RNDW-1:0] r;
        logic signed [RNDW-1:0] l;
        sum = (AW+1)'(a) + 33'sd16384;
        r   = RNDW'(sum >>> 15);
        l   = RNDW'(lim);
        if (r > l) begin
            r = l;
        end else if (r < -l) begin
            r = -l;
        end
        return r;
    endfunction

endpackage

// ===== design/qte_isqrt.sv =====
// Pipelined floor square root, one result bit per stage, with a passed-along sideband.
module qte_isqrt #(
    parameter int SW = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_vld,
    input  logic [qte_pkg::RADW-1:0]       i_v,
    input  logic [SW-1:0]                  i_side,
    output logic                           o_vld,
    output logic [qte_pkg::ROOTW-1:0]      o_root,
    output logic [SW-1:0]                  o_side
);

    localparam int N = qte_pkg::ROOTW;

    logic [N-1:0]                 r_q    [0:N];
    logic [qte_pkg::REMW-1:0]     r_rem  [0:N];
    logic [SW-1:0]                r_side [0:N];
    logic [N:0]                   r_vld;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0]    <= '0;
            r_rem[0]  <= qte_pkg::REMW'(i_v);
            r_side[0] <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[N-1:0], i_vld};
        end
    end

    for (genvar j = 0; j < N; j++) begin : g_bit
        localparam int K = N - 1 - j;
        logic [qte_pkg::REMW-1:0] trial;

        // (q + 2^k)^2 - q^2
        assign trial = (qte_pkg::REMW'(r_q[j]) << (K + 1))
                     + (qte_pkg::REMW'(1) << (2 * K));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_rem[j] >= trial) begin
                    r_rem[j+1] <= r_rem[j] - trial;
                    r_q[j+1]   <= r_q[j] | (N'(1) << K);
                end else begin
                    r_rem[j+1] <= r_rem[j];
                    r_q[j+1]   <= r_q[j];
                end
                r_side[j+1] <= r_side[j];
            end
        end
    end

    assign o_vld  = r_vld[N];
    assign o_root = r_q[N];
    assign o_side = r_side[N];

endmodule

// ===== design/qte_cordic.sv =====
// Pipelined vectoring CORDIC: angle of (x, y) in Q.28 radians, one iteration per stage.
module qte_cordic #(
    parameter int STAGES = 16,
    parameter int W      = 37,
    parameter int SW     = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic signed [W-1:0]           i_x,
    input  logic signed [W-1:0]           i_y,
    input  logic [SW-1:0]                 i_side,
    output logic                          o_vld,
    output logic signed [qte_pkg::AW-1:0] o_z,
    output logic [SW-1:0]                 o_side
);

    logic signed [W-1:0]           r_x    [0:STAGES];
    logic signed [W-1:0]           r_y    [0:STAGES];
    logic signed [qte_pkg::AW-1:0] r_z    [0:STAGES];
    logic [SW-1:0]                 r_side [0:STAGES];
    logic [STAGES:0]               r_zero;
    logic [STAGES:0]               r_vld;

    logic signed [W-1:0]           n_x;
    logic signed [W-1:0]           n_y;
    logic signed [qte_pkg::AW-1:0] n_z;

    // Fold the left half plane into the right one
    always_comb begin
        if (i_x < 0) begin
            if (i_y >= 0) begin
                n_x = i_y;
                n_y = -i_x;
                n_z = qte_pkg::PI2_Q28;
            end else begin
                n_x = -i_y;
                n_y = i_x;
                n_z = -qte_pkg::PI2_Q28;
            end
        end else begin
            n_x = i_x;
            n_y = i_y;
            n_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= n_x;
            r_y[0]    <= n_y;
            r_z[0]    <= n_z;
            r_side[0] <= i_side;
            r_zero[0] <= (i_x == 0) && (i_y == 0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[STAGES-1:0], i_vld};
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_iter
        localparam logic signed [qte_pkg::AW-1:0] A = qte_pkg::atan_q28(i);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[i] > 0) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + A;
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - A;
                end
                r_zero[i+1] <= r_zero[i];
                r_side[i+1] <= r_side[i];
            end
        end
    end

    assign o_vld  = r_vld[STAGES];
    assign o_z    = r_zero[STAGES] ? '0 : r_z[STAGES];
    assign o_side = r_side[STAGES];

endmodule

// ===== design/quaternion_to_euler_top.sv =====
// Top level of the quaternion to Euler angle converter.
//
// Converts one quaternion (x, y, z, w in signed Q1.14) per cycle into Euler
// angles in Q.13 radians plus a gimbal-lock flag. The block is a fully
// pipelined datapath: one transfer in and one transfer out every clock while
// the output register is not held. The
// latency is set by three chains: a 29-stage bit-per-cycle square root that
// forms the cosine of the x-angle, the x-angle CORDIC, and then the y/z-angle
// CORDICs, which start only once the lock decision is known. When the output
// register holds a result that is not taken, the whole pipeline holds and
// s_tready drops in the same cycle; nothing is dropped or repeated. The
// threshold register may only be written while the pipeline is empty.
module quaternion_to_euler_top #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // threshold register
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,
    // quaternion stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // quat_x[15:0], quat_y[31:16], quat_z[47:32], quat_w[63:48]
    // angle stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // angle_x[14:0], angle_y[30:15], angle_z[46:31], zero pad
    output logic        m_tuser    // gimbal_lock
);

    localparam int SUMW = qte_pkg::SUMW;
    localparam int OPSW = $bits(qte_pkg::t_ops);

    logic en;

    logic [qte_pkg::THRW-1:0] r_thr;
    logic signed [SUMW-1:0]   eps;

    // Whole pipeline advances unless the output register is held.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= qte_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    assign eps = SUMW'({r_thr, 14'd0});

    // ---------------- stage 1: component products ----------------
    logic signed [qte_pkg::QW-1:0] qx, qy, qz, qw;
    logic signed [qte_pkg::PW-1:0] r_xy, r_xz, r_xw, r_yy, r_yz, r_yw, r_zz, r_zw, r_ww;
    logic r_v1;

    assign qx = s_tdata[15:0];
    assign qy = s_tdata[31:16];
    assign qz = s_tdata[47:32];
    assign qw = s_tdata[63:48];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xy <= qx * qy;
            r_xz <= qx * qz;
            r_xw <= qx * qw;
            r_yy <= qy * qy;
            r_yz <= qy * qz;
            r_yw <= qy * qw;
            r_zz <= qz * qz;
            r_zw <= qz * qw;
            r_ww <= qw * qw;
        end
    end

    // ---------------- stage 2: doubled sums ----------------
    logic signed [SUMW-1:0] r2_s, r2_sy, r2_xl, r2_xn, r2_zy, r2_zx;
    logic r_v2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_s  <= (SUMW'(r_yz) - SUMW'(r_xw)) <<< 1;
            r2_sy <= (SUMW'(r_xz) + SUMW'(r_yw)) <<< 1;
            r2_xl <= qte_pkg::ONE_Q28 - ((SUMW'(r_yy) + SUMW'(r_zz)) <<< 1);
            r2_xn <= ((SUMW'(r_ww) + SUMW'(r_zz)) <<< 1) - qte_pkg::ONE_Q28;
            r2_zy <= (SUMW'(r_xy) + SUMW'(r_zw)) <<< 1;
            r2_zx <= ((SUMW'(r_ww) + SUMW'(r_yy)) <<< 1) - qte_pkg::ONE_Q28;
        end
    end

    // ---------------- stage 3: zero the small sine, early lock ----------------
    logic signed [SUMW-1:0]      abs_s;
    logic                        s_small;
    logic                        n_lock0;
    qte_pkg::t_ops               r3_ops;
    logic [qte_pkg::ROOTW-1:0]   r3_mag;
    logic r_v3;

    assign abs_s   = (r2_s < 0) ? -r2_s : r2_s;
    assign s_small = abs_s < eps;
    assign n_lock0 = !s_small && (abs_s > qte_pkg::ONE_Q28);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_ops.u     <= s_small ? '0 : -r2_s;
            r3_ops.lock0 <= n_lock0;
            r3_ops.sy    <= r2_sy;
            r3_ops.xl    <= r2_xl;
            r3_ops.xn    <= r2_xn;
            r3_ops.zy    <= r2_zy;
            r3_ops.zx    <= r2_zx;
            // magnitude only matters when not locked; it is then at most one
            r3_mag       <= (s_small || n_lock0) ? '0 : abs_s[qte_pkg::ROOTW-1:0];
        end
    end

    // ---------------- stage 4: square of the sine ----------------
    logic [2*qte_pkg::ROOTW-1:0] r4_sq;
    qte_pkg::t_ops               r4_ops;
    logic r_v4;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_sq  <= r3_mag * r3_mag;
            r4_ops <= r3_ops;
        end
    end

    // ---------------- stage 5: radicand 1 - sine^2 ----------------
    logic [qte_pkg::RADW-1:0] r5_v;
    qte_pkg::t_ops            r5_ops;
    logic r_v5;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_v   <= (qte_pkg::RADW'(1) << 56) - r4_sq[qte_pkg::RADW-1:0];
            r5_ops <= r4_ops;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v1 <= s_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // ---------------- cosine of the x-angle ----------------
    logic                      sq_vld;
    logic [qte_pkg::ROOTW-1:0] sq_root;
    logic [OPSW-1:0]           sq_side;

    qte_isqrt #(
        .SW (OPSW)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_v5),
        .i_v     (r5_v),
        .i_side  (r5_ops),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // ---------------- x-angle = atan2(sine, cosine) ----------------
    qte_pkg::t_ops                 sq_ops;
    logic                          cx_vld;
    logic signed [qte_pkg::AW-1:0] cx_z;
    logic [OPSW-1:0]               cx_side;
    qte_pkg::t_ops                 cx_ops;

    assign sq_ops = sq_side;

    qte_cordic #(
        .STAGES (CORDIC_STAGES),
        .W      (qte_pkg::CW),
        .SW     (OPSW)
    ) u_cordic_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (sq_vld),
        .i_x     (qte_pkg::CW'(sq_root)),
        .i_y     (qte_pkg::CW'(sq_ops.u)),
        .i_side  (sq_side),
        .o_vld   (cx_vld),
        .o_z     (cx_z),
        .o_side  (cx_side)
    );

    assign cx_ops = cx_side;

    // ---------------- lock decision ----------------
    logic signed [qte_pkg::AW-1:0] abs_ax;
    logic signed [qte_pkg::AW:0]   d;
    logic signed [qte_pkg::AW:0]   abs_d;
    logic                          n_lock;
    logic                          r6_lock;
    logic signed [qte_pkg::AW-1:0] r6_ax;
    logic signed [SUMW-1:0]        r6_yy, r6_yx, r6_zy, r6_zx;
    logic                          r_v6;

    assign abs_ax = (cx_z < 0) ? -cx_z : cx_z;
    assign d      = (qte_pkg::AW+1)'(qte_pkg::PI2_Q28) - (qte_pkg::AW+1)'(abs_ax);
    assign abs_d  = (d < 0) ? -d : d;
    assign n_lock = cx_ops.lock0 || (abs_d < (qte_pkg::AW+1)'(eps));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_lock <= n_lock;
            if (n_lock) begin
                r6_ax <= (cx_ops.u >= 0) ? qte_pkg::PI2_Q28 : -qte_pkg::PI2_Q28;
            end else begin
                r6_ax <= cx_z;
            end
            r6_yy <= cx_ops.sy;
            r6_yx <= n_lock ? cx_ops.xl : cx_ops.xn;
            r6_zy <= cx_ops.zy;
            r6_zx <= cx_ops.zx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (en) begin
            r_v6 <= cx_vld;
        end
    end

    // ---------------- y- and z-angle CORDICs side by side ----------------
    logic                          cy_vld, cz_vld;
    logic signed [qte_pkg::AW-1:0] cy_z, cz_z;
    logic [qte_pkg::AW:0]          cy_side;
    logic                          cz_lock;
    logic signed [qte_pkg::AW-1:0] ax_fin;

    qte_cordic #(
        .STAGES (CORDIC_STAGES),
        .W      (qte_pkg::CW),
        .SW     (qte_pkg::AW + 1)
    ) u_cordic_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_v6),
        .i_x     (qte_pkg::CW'(r6_yx)),
        .i_y     (qte_pkg::CW'(r6_yy)),
        .i_side  ({r6_lock, r6_ax}),
        .o_vld   (cy_vld),
        .o_z     (cy_z),
        .o_side  (cy_side)
    );

    qte_cordic #(
        .STAGES (CORDIC_STAGES),
        .W      (qte_pkg::CW),
        .SW     (1)
    ) u_cordic_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_v6),
        .i_x     (qte_pkg::CW'(r6_zx)),
        .i_y     (qte_pkg::CW'(r6_zy)),
        .i_side  (r6_lock),
        .o_vld   (cz_vld),
        .o_z     (cz_z),
        .o_side  (cz_lock)
    );

    assign ax_fin = cy_side[qte_pkg::AW-1:0];

    // ---------------- output register: round, saturate, pack ----------------
    logic signed [qte_pkg::RNDW-1:0] rx, ry, rz;

    assign rx = qte_pkg::q13_sat(ax_fin, qte_pkg::PIX_MAX);
    assign ry = qte_pkg::q13_sat(cy_z, qte_pkg::PIY_MAX);
    assign rz = qte_pkg::q13_sat(cz_z, qte_pkg::PIY_MAX);

    always_ff @(posedge i_clk) begin
        if (en) begin
            m_tdata <= {1'b0,
                        cz_lock ? {qte_pkg::AYW{1'b0}} : rz[qte_pkg::AYW-1:0],
                        ry[qte_pkg::AYW-1:0],
                        rx[qte_pkg::AXW-1:0]};
            m_tuser <= cy_side[qte_pkg::AW];
        end
    end

    // Hold the result until the transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tvalid <= 1'b0;
        end else if (en) begin
            m_tvalid <= cy_vld && cz_vld;
        end
    end

endmodule

// ===== design/qte_chk.sv =====
// Port-level checks for the quaternion to Euler converter, bound to the top level.
module qte_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_lock_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser |-> m_tdata[46:31] == 16'd0)
        else $error("z-angle not zero under gimbal lock");

    a_lock_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser |-> m_tdata[14:0] == 15'd12868 || m_tdata[14:0] == 15'd19900)
        else $error("x-angle not at a pole under gimbal lock");

    a_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> $signed(m_tdata[14:0]) <= 15'sd12868
                  && $signed(m_tdata[14:0]) >= -15'sd12868)
        else $error("x-angle out of range");

endmodule

bind quaternion_to_euler_top qte_chk u_qte_chk (.*);

// ===== tb/sv/quaternion_to_euler_top_test.sv =====
// Self-checking testbench for the quaternion to Euler angle converter.
module quaternion_to_euler_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int    STAGES     = 16;        // CORDIC iterations of the instance
    localparam longint UNIT_Q28  = 64'sd1 << 28;
    localparam longint HALF_PI   = 64'sd421657428;
    localparam longint QUART_PI  = 64'sd210828714;
    localparam longint LIM_X     = 12868;
    localparam longint LIM_YZ    = 25736;
    localparam int    DRAIN_WAIT = 90;        // extra wait once all predictions have returned

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [15:0] w;
    } quat_t;

    typedef struct packed {
        logic signed [14:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic               lock;
    } euler_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [10:0] i_cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;   // quat_x, quat_y, quat_z, quat_w from bit 0 up
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // angle_x, angle_y, angle_z, zero pad
    logic        m_tuser;        // gimbal_lock

    quaternion_to_euler_top #(.CORDIC_STAGES(STAGES)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    quat_t       quat_q[$];      // quaternions waiting for the driver
    euler_t      angle_q[$];     // predicted angles in transfer order
    logic [10:0] thr_shadow = 11'd16;
    longint      atan_rom[STAGES];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          n_errors = 0;
    bit          quat_taken = 1'b0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    // atan(2^-i) in Q.28 from the arctangent series evaluated at Q.56
    function automatic longint atan_term(int i);
        longint acc;
        longint e;
        acc = 0;
        if (i == 0) return QUART_PI;
        for (int k = 0; k < 64; k++) begin
            e = longint'(i) * (2 * k + 1);
            if (e > 56) break;
            if (k % 2) acc -= (64'sd1 << (56 - e)) / (2 * k + 1);
            else       acc += (64'sd1 << (56 - e)) / (2 * k + 1);
        end
        return (acc + (64'sd1 << 27)) >>> 28;
    endfunction

    // CORDIC vectoring: angle of (px, py) in Q.28 radians
    function automatic longint cordic_angle(longint py, longint px);
        longint ang;
        longint t;
        longint xs;
        longint ys;
        ang = 0;
        if (px == 0 && py == 0) return 0;
        if (px < 0) begin
            if (py >= 0) begin
                t = px; px = py; py = -t; ang = HALF_PI;
            end else begin
                t = px; px = -py; py = t; ang = -HALF_PI;
            end
        end
        for (int i = 0; i < STAGES; i++) begin
            xs = px >>> i;
            ys = py >>> i;
            if (py > 0) begin
                px += ys; py -= xs; ang += atan_rom[i];
            end else begin
                px -= ys; py += xs; ang -= atan_rom[i];
            end
        end
        return ang;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b; r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // round Q.28 to nearest Q.13, ties up, then clamp
    function automatic longint round_q13(longint a, longint lim);
        longint r;
        r = (a + (64'sd1 << 14)) >>> 15;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic euler_t predict_angles(quat_t q, logic [10:0] thr);
        longint qx, qy, qz, qw, eps, s, u, mag, sy, ax, ay, az, d;
        longint unsigned c;
        bit     lock;
        euler_t e;
        qx = q.x; qy = q.y; qz = q.z; qw = q.w;
        eps  = longint'(thr) << 14;
        s    = 2 * (qy * qz - qx * qw);
        sy   = 2 * (qx * qz + qy * qw);
        lock = 0;
        ax   = 0;
        az   = 0;
        // zero a sine that is smaller than the threshold
        if ((s < 0 ? -s : s) < eps) s = 0;
        u   = -s;
        mag = u < 0 ? -u : u;
        if (mag > UNIT_Q28) begin
            lock = 1;
        end else begin
            c  = root_floor((64'd1 << 56) - longint'(mag * mag));
            ax = cordic_angle(u, longint'(c));
            d  = HALF_PI - (ax < 0 ? -ax : ax);
            if (d < 0) d = -d;
            if (d < eps) lock = 1;
        end
        if (lock) begin
            ax = u >= 0 ? HALF_PI : -HALF_PI;
            ay = cordic_angle(sy, UNIT_Q28 - 2 * (qy * qy + qz * qz));
        end else begin
            ay = cordic_angle(sy, 2 * (qw * qw + qz * qz) - UNIT_Q28);
            az = cordic_angle(2 * (qx * qy + qz * qw), 2 * (qw * qw + qy * qy) - UNIT_Q28);
        end
        e.ax   = 15'(round_q13(ax, LIM_X));
        e.ay   = 16'(round_q13(ay, LIM_YZ));
        e.az   = lock ? 16'sd0 : 16'(round_q13(az, LIM_YZ));
        e.lock = lock;
        return e;
    endfunction

    // ---------------------------------------------------------------- driver

    // Record transfers and predict; the threshold shadow follows register writes.
    always @(posedge i_clk) begin
        if (i_cfg_we) thr_shadow = i_cfg_wdata;
        if (s_tvalid && s_tready) begin
            angle_q.push_back(predict_angles(quat_t'({s_tdata[15:0], s_tdata[31:16],
                                                      s_tdata[47:32], s_tdata[63:48]}),
                                             thr_shadow));
            quat_taken = 1'b1;
        end
    end

    // Hold the quaternion until it transfers, then advance or idle at random.
    always @(negedge i_clk) begin
        quat_t q;
        if (i_rst_n && (!s_tvalid || quat_taken)) begin
            if (quat_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                q = quat_q.pop_front();
                s_tdata  <= {q.w, q.z, q.y, q.x};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        quat_taken = 1'b0;
        m_tready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge i_clk) begin
        euler_t e;
        if (m_tvalid && m_tready) begin
            if (angle_q.size() == 0) begin
                $error("angle transfer with no prediction pending");
                n_errors++;
            end else begin
                e = angle_q.pop_front();
                if (m_tdata[14:0] !== e.ax) begin
                    $error("angle_x expected %0d got %0d", e.ax, $signed(m_tdata[14:0]));
                    n_errors++;
                end
                if (m_tdata[30:15] !== e.ay) begin
                    $error("angle_y expected %0d got %0d", e.ay, $signed(m_tdata[30:15]));
                    n_errors++;
                end
                if (m_tdata[46:31] !== e.az) begin
                    $error("angle_z expected %0d got %0d", e.az, $signed(m_tdata[46:31]));
                    n_errors++;
                end
                if (m_tuser !== e.lock) begin
                    $error("gimbal_lock expected %0d got %0d", e.lock, m_tuser);
                    n_errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic quat_t make_quat(int x, int y, int z, int w);
        quat_t q;
        q.x = 16'(x); q.y = 16'(y); q.z = 16'(z); q.w = 16'(w);
        return q;
    endfunction

    function automatic real rand_unit();
        return (real'($urandom_range(20000)) - 10000.0) / 10000.0;
    endfunction

    // Mostly unit quaternions, some near gimbal lock, some raw 16-bit noise.
    function automatic quat_t rand_quat();
        real v[4];
        real n;
        real jit;
        int  mode;
        quat_t q;
        mode = $urandom_range(9);
        if (mode < 2) begin
            q = quat_t'({$urandom(), $urandom()});
            return q;
        end
        if (mode < 7) begin
            foreach (v[i]) v[i] = rand_unit();
        end else begin
            // yz - xw near 1/2 drives the sine toward 1, or near 0 when the signs flip
            jit = 0.0005 * real'($urandom_range(1, 40));
            v[0] = 0.5 + jit * rand_unit();
            v[1] = 0.5 + jit * rand_unit();
            v[2] = 0.5 + jit * rand_unit();
            v[3] = -0.5 + jit * rand_unit();
            if ($urandom_range(1)) begin
                v[0] = -v[0]; v[3] = -v[3];
                v[1] = -v[1];
            end
        end
        n = $sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2] + v[3] * v[3]);
        if (n < 0.01) n = 1.0;
        // perturb the norm now and then so slightly non-unit inputs appear
        if ($urandom_range(4) == 0) n = n * (0.98 + 0.04 * real'($urandom_range(100)) / 100.0);
        return make_quat($rtoi(v[0] / n * 16384.0), $rtoi(v[1] / n * 16384.0),
                         $rtoi(v[2] / n * 16384.0), $rtoi(v[3] / n * 16384.0));
    endfunction

    // Pause the sender until every predicted angle has come back and the pipe is empty.
    task automatic drain_pipe();
        do @(posedge i_clk); while (quat_q.size() != 0 || s_tvalid || angle_q.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [10:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [10:0] thr_list[6];
        int          send_list[6];
        int          recv_list[6];
        thr_list  = '{11'd16, 11'd0, 11'd2047, 11'd1024, 11'd1, 11'd200};
        send_list = '{0, 70, 0, 70, 0, 0};
        recv_list = '{0, 0, 70, 38, 0, 38};
        send_list[5] = 38;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero, identity, extremes of every field, both lock signs
        quat_q.push_back(make_quat(0, 0, 0, 0));
        quat_q.push_back(make_quat(0, 0, 0, 16384));
        quat_q.push_back(make_quat(0, 0, 0, -16384));
        quat_q.push_back(make_quat(16384, 0, 0, 0));
        quat_q.push_back(make_quat(0, 16384, 0, 0));
        quat_q.push_back(make_quat(0, 0, 16384, 0));
        quat_q.push_back(make_quat(-16384, -16384, -16384, -16384));
        quat_q.push_back(make_quat(16384, 16384, 16384, 16384));
        quat_q.push_back(make_quat(-32768, -32768, -32768, -32768));
        quat_q.push_back(make_quat(32767, 32767, 32767, 32767));
        quat_q.push_back(make_quat(32767, -32768, 32767, -32768));
        quat_q.push_back(make_quat(0, 11585, 11585, 0));     // sine +1, lock
        quat_q.push_back(make_quat(0, 11585, -11585, 0));    // sine -1, lock
        quat_q.push_back(make_quat(8192, 8192, 8192, -8192));
        quat_q.push_back(make_quat(8192, -8192, 8192, 8192));
        quat_q.push_back(make_quat(1, 1, 1, 16383));         // tiny sine, zeroed
        quat_q.push_back(make_quat(100, 100, 100, 16380));
        quat_q.push_back(make_quat(0, 0, 16384, 16384));     // non-unit
        quat_q.push_back(make_quat(-1, -1, -1, -1));

        // phases sweep the threshold and the idle/stall mix
        for (int p = 0; p < 6; p++) begin
            if (p > 0) begin
                drain_pipe();
                write_threshold(thr_list[p]);
            end
            send_idle_pct  = send_list[p];
            recv_stall_pct = recv_list[p];
            for (int i = 0; i < 210; i++) quat_q.push_back(rand_quat());
            if (p == 1) begin
                quat_q.push_back(make_quat(0, 11585, 11585, 0));
                quat_q.push_back(make_quat(0, 0, 0, 16384));
            end
        end
        drain_pipe();
        write_threshold(11'($urandom_range(2047)));

        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        foreach (atan_rom[i]) atan_rom[i] = atan_term(i);
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #30ms;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
design/qte_pkg.sv
design/qte_isqrt.sv
design/qte_cordic.sv
design/quaternion_to_euler_top.sv
design/qte_chk.sv
tb/sv/quaternion_to_euler_top_test.sv
